// ----- design/assert_macros.svh -----
// Assertion macros for the transform stack RTL.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while out of reset.
`define ATST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("atst assertion failed");

// Checked on every clock edge, reset included.
`define ATST_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("atst reset assertion failed");

`endif

// ----- design/atst_pkg.sv -----
// Package for the 2-D affine transform stack: types, sizes, sine table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package atst_pkg;

    localparam int STACK_DEPTH        = 8;
    localparam int LVL_W              = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W             = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SIN_IDX_W          = $clog2(SINE_TABLE_ENTRIES);
    localparam int QTR                = SINE_TABLE_ENTRIES / 4;
    localparam int QSHIFT             = 30 - (SIN_IDX_W - 2);
    localparam int ONE_Q16            = 65536;
    localparam int ALPHA_ONE          = 256;
    localparam int QDEPTH             = 2;
    localparam int QPTR_W             = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W             = $clog2(QDEPTH + 1);
    localparam int IN_TDATA_W         = 320;
    localparam int OUT_TDATA_W        = 168;
    localparam int ACC_W              = 51;
    localparam int PROD_W             = 48;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [17:0] trig_t;
    typedef logic signed [15:0] pix_t;

    typedef enum logic [2:0] {
        CMD_PUSH_ROT = 3'd0,
        CMD_PUSH_ID  = 3'd1,
        CMD_POP      = 3'd2,
        CMD_POINT    = 3'd3,
        CMD_SCISSOR  = 3'd4,
        CMD_CLIP_OFF = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DISPATCH,
        BK_POP_RD,
        BK_RUN,
        BK_DRAIN,
        BK_DONE
    } bk_state_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_L02,
        DST_L12,
        DST_NM,
        DST_OX,
        DST_OY
    } dst_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [8:0] alpha;
        trig_t      cos_v;
        trig_t      sin_v;
        q16_t       trans_x;
        q16_t       trans_y;
        q16_t       pivot_x;
        q16_t       pivot_y;
        q16_t       coord_x;
        q16_t       coord_y;
        q16_t       coord_x2;
        q16_t       coord_y2;
        logic [31:0] color;
    } item_t;

    typedef struct packed {
        q16_t        out_x;
        q16_t        out_y;
        logic [31:0] out_color;
        logic        clip_on;
        pix_t        clip_left;
        pix_t        clip_top;
        pix_t        clip_right;
        pix_t        clip_bottom;
        logic        stack_fault;
    } res_t;

    typedef struct packed {
        q16_t [5:0]  m;
        logic [8:0]  alpha;
        logic        clip_on;
        pix_t [3:0]  rect;
    } frame_t;

    typedef struct packed {
        logic       first;
        logic       last;
        logic       negp;
        logic       init;
        dst_t       dst;
        logic [2:0] nidx;
    } acc_tag_t;

    typedef logic [16:0] qtab_t [0:QTR];

    // Integer Taylor series over a quarter turn; f = 2^30 is a quarter turn.
    function automatic logic [16:0] quarter_sine(input longint unsigned f);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (f * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 5; k++) begin
            term = (term * x2) >> 30;
            // Divide by (2k)(2k+1) for the k-th odd term.
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if ((k & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        sum = (sum + 8192) >>> 14;
        if (sum > ONE_Q16) sum = ONE_Q16;
        return sum[16:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int q = 0; q <= QTR; q++) begin
            t[q] = quarter_sine(longint'(q) << QSHIFT);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    // Full-turn sine from the quarter table by symmetry.
    function automatic trig_t sine_at(input logic [SIN_IDX_W-1:0] i);
        logic [1:0]           quad;
        logic [SIN_IDX_W-1:0] q;
        trig_t                mag;
        quad = i[SIN_IDX_W-1:SIN_IDX_W-2];
        q    = quad[0] ? (SIN_IDX_W'(QTR) - {2'b00, i[SIN_IDX_W-3:0]})
                       : {2'b00, i[SIN_IDX_W-3:0]};
        mag  = {1'b0, QTAB[q[SIN_IDX_W-2:0]]};
        return quad[1] ? -mag : mag;
    endfunction

    function automatic q16_t sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(64'sh7FFFFFFF)) return 32'sh7FFFFFFF;
        if (v < -ACC_W'(64'sh80000000)) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ----- design/affine_transform_stack_2d_top.sv -----
// Top level of the 2-D affine transform stack: front end, queue, back end.
// Depends on atst_pkg, atst_front, atst_queue and atst_back.
//
//   channel   dir   tdata                                       tuser
//   s_axis    in    alpha..color, 313 bits in 320               cmd
//   m_axis    out   out_x..clip_bottom, 161 bits in 168         stack_fault
//
// In the back end, push rotate, point and set scissor run through one shared
// 32x32 multiplier; push identity, pop, scissor off and faulting commands do
// not use it. The front end and the queue each hold the item in a register.
// Reset clears state to identity, alpha 256, scissor off and an empty stack.
// A result waits in the output register while the back end, queue and front
// end keep taking up to four more beats.
`timescale 1ns / 1ps
module affine_transform_stack_2d_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // alpha, angle, trans_x, trans_y, pivot_x, pivot_y, coord_x, coord_y,
    // coord_x2, coord_y2, color; zero padded
    input  logic [atst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_x, out_y, out_color, clip_on, clip_left, clip_top, clip_right,
    // clip_bottom; zero padded
    output logic [atst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // stack_fault
    output logic                             m_axis_tuser
);
    import atst_pkg::*;

    logic  f_valid, f_ready;
    item_t f_item;
    logic  q_valid, q_ready;
    item_t q_item;
    res_t  res;

    atst_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (f_valid),
        .item_ready    (f_ready),
        .item          (f_item)
    );

    atst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    atst_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (res)
    );

    assign m_axis_tdata = {7'd0, res.clip_bottom, res.clip_right, res.clip_top,
                           res.clip_left, res.clip_on, res.out_color, res.out_y, res.out_x};
    assign m_axis_tuser = res.stack_fault;

endmodule

// ----- design/atst_front.sv -----
// Front end: takes input beats, unpacks them and looks up sine and cosine.
// Depends on atst_pkg.
`timescale 1ns / 1ps
module atst_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // alpha, angle, trans_x, trans_y, pivot_x, pivot_y, coord_x, coord_y,
    // coord_x2, coord_y2, color; zero padded
    input  logic [atst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [2:0]                       s_axis_tuser,
    output logic                             item_valid,
    input  logic                             item_ready,
    output atst_pkg::item_t                  item
);
    import atst_pkg::*;

    logic                 hold_valid_reg;
    item_t                item_reg;
    item_t                dec;
    logic [SIN_IDX_W-1:0] idx;
    logic [15:0]          angle;

    always_comb begin
        angle        = s_axis_tdata[24:9];
        idx          = angle[15 -: SIN_IDX_W];
        dec.cmd      = cmd_t'(s_axis_tuser);
        dec.alpha    = s_axis_tdata[8:0];
        dec.sin_v    = sine_at(idx);
        dec.cos_v    = sine_at(idx + SIN_IDX_W'(QTR));
        dec.trans_x  = s_axis_tdata[56:25];
        dec.trans_y  = s_axis_tdata[88:57];
        dec.pivot_x  = s_axis_tdata[120:89];
        dec.pivot_y  = s_axis_tdata[152:121];
        dec.coord_x  = s_axis_tdata[184:153];
        dec.coord_y  = s_axis_tdata[216:185];
        dec.coord_x2 = s_axis_tdata[248:217];
        dec.coord_y2 = s_axis_tdata[280:249];
        dec.color    = s_axis_tdata[312:281];
    end

    assign s_axis_tready = !hold_valid_reg || item_ready;
    assign item_valid    = hold_valid_reg;
    assign item          = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            hold_valid_reg <= 1'b1;
        end else if (item_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= dec;
        end
    end

endmodule

// ----- design/atst_queue.sv -----
// Short queue of decoded items between the front end and the back end.
// Depends on atst_pkg.
`timescale 1ns / 1ps
module atst_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  atst_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output atst_pkg::item_t out_item
);
    import atst_pkg::*;

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg < QCNT_W'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- design/atst_back.sv -----
// Back end: state, save stack and a sequencer around one shared multiplier.
// Depends on atst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module atst_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  atst_pkg::item_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output atst_pkg::res_t  m_res
);
    import atst_pkg::*;

    bk_state_t   state_reg, state_next;
    item_t       item_reg;
    q16_t [5:0]  m_reg;
    logic [8:0]  alpha_reg;
    logic        clip_on_reg;
    pix_t [3:0]  rect_reg;
    logic [LVL_W-1:0] level_reg;
    logic        fault_reg;

    frame_t      stk_mem [STACK_DEPTH];
    frame_t      rd_reg;

    logic [3:0]  step_reg;
    logic [3:0]  last_step;
    q16_t        l02_reg, l12_reg;
    q16_t [5:0]  nm_reg;
    q16_t        ox_reg, oy_reg;
    q16_t        mnx_reg, mxx_reg, mny_reg, mxy_reg;

    logic                       v2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    q16_t                       extra_reg;
    acc_tag_t                   tag_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    res_t        res_reg;
    logic        m_valid_reg;

    logic        full, empty;
    logic        issue, out_load;
    logic        mem_we, mem_re;
    logic [LVL_W-1:0] level_m1;
    logic        stack_cmd;

    q16_t        a_op, b_op, extra_op;
    acc_tag_t    tag_op;
    logic signed [63:0] p64;
    logic signed [63:0] r64;

    logic signed [ACC_W-1:0] pterm, base, sum;
    q16_t        sum_sat;

    q16_t        px, py;
    q16_t        cs_q, sn_q, nsn_q;
    logic [16:0] na_prod;
    logic [7:0]  na;
    logic signed [32:0] ceil_x, ceil_y;
    pix_t        right_v, bottom_v;
    logic        clip_on_new;
    pix_t [3:0]  rect_new;
    res_t        res_next;
    frame_t      cur_frame;

    assign full     = level_reg >= LVL_W'(STACK_DEPTH);
    assign empty    = level_reg == '0;
    assign level_m1 = level_reg - 1'b1;
    assign stack_cmd = item_reg.cmd == CMD_PUSH_ROT || item_reg.cmd == CMD_PUSH_ID
                       || item_reg.cmd == CMD_POP;

    assign cur_frame.m       = m_reg;
    assign cur_frame.alpha   = alpha_reg;
    assign cur_frame.clip_on = clip_on_reg;
    assign cur_frame.rect    = rect_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) state_next = BK_DISPATCH;
            end
            BK_DISPATCH: begin
                case (item_reg.cmd)
                    CMD_PUSH_ROT: state_next = full ? BK_DONE : BK_RUN;
                    CMD_POP:      state_next = empty ? BK_DONE : BK_POP_RD;
                    CMD_POINT:    state_next = BK_RUN;
                    CMD_SCISSOR:  state_next = BK_RUN;
                    default:      state_next = BK_DONE;
                endcase
            end
            BK_POP_RD: state_next = BK_DONE;
            BK_RUN: begin
                if (step_reg == last_step) state_next = BK_DRAIN;
            end
            BK_DRAIN: state_next = BK_DONE;
            BK_DONE: begin
                if (out_load) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        q_ready  = state_reg == BK_IDLE;
        issue    = state_reg == BK_RUN;
        out_load = (state_reg == BK_DONE) && (!m_valid_reg || m_ready);
        mem_we   = (state_reg == BK_DISPATCH) && !full
                   && (item_reg.cmd == CMD_PUSH_ROT || item_reg.cmd == CMD_PUSH_ID);
        mem_re   = (state_reg == BK_DISPATCH) && !empty && (item_reg.cmd == CMD_POP);
    end

    assign last_step = (item_reg.cmd == CMD_POINT) ? 4'd3 : 4'd15;

    // Microcode: operands and accumulate tag for the current step.
    always_comb begin
        cs_q  = {{14{item_reg.cos_v[17]}}, item_reg.cos_v};
        sn_q  = {{14{item_reg.sin_v[17]}}, item_reg.sin_v};
        nsn_q = -sn_q;
        case (step_reg[3:2])
            2'd0:    begin px = item_reg.coord_x;  py = item_reg.coord_y;  end
            2'd1:    begin px = item_reg.coord_x2; py = item_reg.coord_y;  end
            2'd2:    begin px = item_reg.coord_x2; py = item_reg.coord_y2; end
            default: begin px = item_reg.coord_x;  py = item_reg.coord_y2; end
        endcase
        a_op        = '0;
        b_op        = '0;
        extra_op    = '0;
        tag_op      = '0;
        tag_op.dst  = DST_NONE;
        if (item_reg.cmd == CMD_PUSH_ROT) begin
            case (step_reg)
                4'd0: begin
                    a_op = cs_q; b_op = item_reg.pivot_x; extra_op = item_reg.pivot_x;
                    tag_op.first = 1'b1; tag_op.negp = 1'b1;
                end
                4'd1: begin
                    a_op = sn_q; b_op = item_reg.pivot_y; extra_op = item_reg.trans_x;
                    tag_op.last = 1'b1; tag_op.dst = DST_L02;
                end
                4'd2: begin
                    a_op = sn_q; b_op = item_reg.pivot_x; extra_op = item_reg.pivot_y;
                    tag_op.first = 1'b1; tag_op.negp = 1'b1;
                end
                4'd3: begin
                    a_op = cs_q; b_op = item_reg.pivot_y; extra_op = item_reg.trans_y;
                    tag_op.negp = 1'b1; tag_op.last = 1'b1; tag_op.dst = DST_L12;
                end
                4'd4:  begin a_op = m_reg[0]; b_op = cs_q;  tag_op.first = 1'b1; end
                4'd5:  begin
                    a_op = m_reg[1]; b_op = sn_q;
                    tag_op.last = 1'b1; tag_op.dst = DST_NM; tag_op.nidx = 3'd0;
                end
                4'd6:  begin a_op = m_reg[0]; b_op = nsn_q; tag_op.first = 1'b1; end
                4'd7:  begin
                    a_op = m_reg[1]; b_op = cs_q;
                    tag_op.last = 1'b1; tag_op.dst = DST_NM; tag_op.nidx = 3'd1;
                end
                4'd8:  begin
                    a_op = m_reg[0]; b_op = l02_reg; extra_op = m_reg[2];
                    tag_op.first = 1'b1;
                end
                4'd9:  begin
                    a_op = m_reg[1]; b_op = l12_reg;
                    tag_op.last = 1'b1; tag_op.dst = DST_NM; tag_op.nidx = 3'd2;
                end
                4'd10: begin a_op = m_reg[3]; b_op = cs_q;  tag_op.first = 1'b1; end
                4'd11: begin
                    a_op = m_reg[4]; b_op = sn_q;
                    tag_op.last = 1'b1; tag_op.dst = DST_NM; tag_op.nidx = 3'd3;
                end
                4'd12: begin a_op = m_reg[3]; b_op = nsn_q; tag_op.first = 1'b1; end
                4'd13: begin
                    a_op = m_reg[4]; b_op = cs_q;
                    tag_op.last = 1'b1; tag_op.dst = DST_NM; tag_op.nidx = 3'd4;
                end
                4'd14: begin
                    a_op = m_reg[3]; b_op = l02_reg; extra_op = m_reg[5];
                    tag_op.first = 1'b1;
                end
                default: begin
                    a_op = m_reg[4]; b_op = l12_reg;
                    tag_op.last = 1'b1; tag_op.dst = DST_NM; tag_op.nidx = 3'd5;
                end
            endcase
        end else begin
            // Point and scissor corners: x then y of one corner per four steps.
            tag_op.init = step_reg[3:2] == 2'd0;
            case (step_reg[1:0])
                2'd0: begin
                    a_op = m_reg[0]; b_op = px; extra_op = m_reg[2]; tag_op.first = 1'b1;
                end
                2'd1: begin
                    a_op = m_reg[1]; b_op = py; tag_op.last = 1'b1; tag_op.dst = DST_OX;
                end
                2'd2: begin
                    a_op = m_reg[3]; b_op = px; extra_op = m_reg[5]; tag_op.first = 1'b1;
                end
                default: begin
                    a_op = m_reg[4]; b_op = py; tag_op.last = 1'b1; tag_op.dst = DST_OY;
                end
            endcase
        end
    end

    // Stage one: multiply and round to Q16.16.
    assign p64 = a_op * b_op;
    assign r64 = p64 + 64'sd32768;

    // Stage two: accumulate rounded products with the added term.
    always_comb begin
        pterm   = tag_reg.negp ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
        base    = tag_reg.first ? '0 : acc_reg;
        sum     = base + pterm + ACC_W'(extra_reg);
        sum_sat = sat32(sum);
    end

    // Result and state after this item.
    always_comb begin
        na_prod  = item_reg.color[31:24] * alpha_reg;
        na       = (na_prod[16:8] > 9'd255) ? 8'd255 : na_prod[15:8];
        ceil_x   = {mxx_reg[31], mxx_reg} + 33'sd65535;
        ceil_y   = {mxy_reg[31], mxy_reg} + 33'sd65535;
        right_v  = ($signed(ceil_x[32:16]) > 17'sd32767) ? 16'sh7FFF : ceil_x[31:16];
        bottom_v = ($signed(ceil_y[32:16]) > 17'sd32767) ? 16'sh7FFF : ceil_y[31:16];
        clip_on_new = clip_on_reg;
        rect_new    = rect_reg;
        case (item_reg.cmd)
            CMD_SCISSOR: begin
                clip_on_new = 1'b1;
                rect_new[0] = mnx_reg[31:16];
                rect_new[1] = mny_reg[31:16];
                rect_new[2] = right_v;
                rect_new[3] = bottom_v;
            end
            CMD_CLIP_OFF: clip_on_new = 1'b0;
            default: ;
        endcase
        res_next             = '0;
        if (item_reg.cmd == CMD_POINT) begin
            res_next.out_x     = ox_reg;
            res_next.out_y     = oy_reg;
            res_next.out_color = {na, item_reg.color[23:0]};
        end
        res_next.clip_on     = clip_on_new;
        res_next.clip_left   = rect_new[0];
        res_next.clip_top    = rect_new[1];
        res_next.clip_right  = rect_new[2];
        res_next.clip_bottom = rect_new[3];
        res_next.stack_fault = fault_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_reg       <= {32'sd0, 32'(ONE_Q16), 32'sd0, 32'sd0, 32'sd0, 32'(ONE_Q16)};
            alpha_reg   <= 9'(ALPHA_ONE);
            clip_on_reg <= 1'b0;
            rect_reg    <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            v2_reg    <= issue;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (state_reg == BK_DISPATCH) begin
                if (mem_we) level_reg <= level_reg + 1'b1;
                if (mem_re) level_reg <= level_m1;
                if (item_reg.cmd == CMD_PUSH_ID && !full) begin
                    m_reg     <= {32'sd0, 32'(ONE_Q16), 32'sd0, 32'sd0, 32'sd0, 32'(ONE_Q16)};
                    alpha_reg <= 9'(ALPHA_ONE);
                end
            end
            if (state_reg == BK_POP_RD) begin
                m_reg       <= rd_reg.m;
                alpha_reg   <= rd_reg.alpha;
                clip_on_reg <= rd_reg.clip_on;
                rect_reg    <= rd_reg.rect;
            end
            if (out_load) begin
                clip_on_reg <= clip_on_new;
                rect_reg    <= rect_new;
                if (item_reg.cmd == CMD_PUSH_ROT && !fault_reg) begin
                    m_reg <= nm_reg;
                    if (item_reg.alpha < alpha_reg) alpha_reg <= item_reg.alpha;
                end
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) item_reg <= q_item;
        if (state_reg == BK_DISPATCH) begin
            step_reg  <= '0;
            fault_reg <= (full && (item_reg.cmd == CMD_PUSH_ROT || item_reg.cmd == CMD_PUSH_ID))
                         || (empty && item_reg.cmd == CMD_POP);
        end else if (issue) begin
            step_reg <= step_reg + 1'b1;
        end
        prod_reg  <= r64[63:16];
        extra_reg <= extra_op;
        tag_reg   <= tag_op;
        if (v2_reg) begin
            acc_reg <= sum;
            if (tag_reg.last) begin
                case (tag_reg.dst)
                    DST_L02: l02_reg <= sum_sat;
                    DST_L12: l12_reg <= sum_sat;
                    DST_NM:  nm_reg[tag_reg.nidx] <= sum_sat;
                    DST_OX: begin
                        ox_reg <= sum_sat;
                        if (tag_reg.init || sum_sat < mnx_reg) mnx_reg <= sum_sat;
                        if (tag_reg.init || sum_sat > mxx_reg) mxx_reg <= sum_sat;
                    end
                    DST_OY: begin
                        oy_reg <= sum_sat;
                        if (tag_reg.init || sum_sat < mny_reg) mny_reg <= sum_sat;
                        if (tag_reg.init || sum_sat > mxy_reg) mxy_reg <= sum_sat;
                    end
                    default: ;
                endcase
            end
        end
        if (out_load) res_reg <= res_next;
    end

    // Save stack, one whole frame per row.
    always_ff @(posedge aclk) begin
        if (mem_we) stk_mem[level_reg[SIDX_W-1:0]] <= cur_frame;
        if (mem_re) rd_reg <= stk_mem[level_m1[SIDX_W-1:0]];
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    `ATST_ASSERT(a_level_bound, level_reg <= LVL_W'(STACK_DEPTH))
    `ATST_ASSERT(a_fault_cmd, (state_reg == BK_DONE && fault_reg) |-> stack_cmd)
    `ATST_ASSERT(a_drain_after_run, state_reg == BK_DRAIN |-> $past(state_reg) == BK_RUN)
    `ATST_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == BK_IDLE && !m_valid_reg))

endmodule

// ----- tb/tb_affine_transform_stack_2d_top.sv -----
// Self-checking testbench for the 2-D affine transform stack.
// Drives command beats with random gaps and checks every result against a predictor.
// Depends on atst_pkg and affine_transform_stack_2d_top.
`timescale 1ns / 1ps

class transform_scoreboard;
    logic signed [31:0] mat [6];
    logic [8:0]         cur_a;
    logic               clip_en;
    logic signed [15:0] rect [4];
    logic signed [31:0] sv_mat [8][6];
    logic [8:0]         sv_a [8];
    logic               sv_clip [8];
    logic signed [15:0] sv_rect [8][4];
    int                 level;
    logic [167:0]       want_data [$];
    logic               want_fault [$];
    int                 errors;
    logic signed [31:0] sin_lut [1024];
    logic signed [31:0] cos_lut [1024];

    function new();
        for (int i = 0; i < 1024; i++) begin
            longint unsigned ph;
            ph = (longint'(i) << 32) / 1024;
            sin_lut[i] = phase_sine(ph[31:0]);
            cos_lut[i] = phase_sine(ph[31:0] + 32'h4000_0000);
        end
        mat = '{65536, 0, 0, 0, 65536, 0};
        cur_a = 256;
        clip_en = 0;
        rect = '{0, 0, 0, 0};
        level = 0;
        errors = 0;
    endfunction

    function longint qsine(longint unsigned f);
        longint unsigned x, x2, term;
        longint acc;
        x = (f * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 8192) >>> 14;
        if (acc > 65536) acc = 65536;
        return acc;
    endfunction

    function longint phase_sine(logic [31:0] ph);
        longint unsigned f;
        longint s;
        f = ph[29:0];
        s = ph[30] ? qsine(64'h4000_0000 - f) : qsine(f);
        return ph[31] ? -s : s;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // Rounded Q16.16 product; >>> on a signed longint floors.
    function longint qmul(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function void map_point(longint x, longint y, output longint ox, output longint oy);
        ox = sat32(qmul(mat[0], x) + qmul(mat[1], y) + mat[2]);
        oy = sat32(qmul(mat[3], x) + qmul(mat[4], y) + mat[5]);
    endfunction

    function void push_state();
        for (int j = 0; j < 6; j++) sv_mat[level][j] = mat[j];
        sv_a[level] = cur_a;
        sv_clip[level] = clip_en;
        for (int j = 0; j < 4; j++) sv_rect[level][j] = rect[j];
        level++;
    endfunction

    function void note_input(logic [2:0] op, logic [8:0] al, logic [15:0] ang,
                             logic signed [31:0] offx, logic signed [31:0] offy,
                             logic signed [31:0] pvx, logic signed [31:0] pvy,
                             logic signed [31:0] cx, logic signed [31:0] cy,
                             logic signed [31:0] cx2, logic signed [31:0] cy2,
                             logic [31:0] col);
        longint rx, ry, c, s, l02, l12;
        longint xs [4], ys [4];
        longint p [6];
        longint mnx, mny, mxx, mxy;
        longint scaled;
        logic [31:0] rcol;
        logic [7:0] na;
        logic fault;
        rx = 0; ry = 0; rcol = 0; fault = 0;
        case (op)
            atst_pkg::CMD_PUSH_ROT: begin
                if (level >= 8) fault = 1;
                else begin
                    c = cos_lut[ang[15:6]];
                    s = sin_lut[ang[15:6]];
                    push_state();
                    l02 = sat32(pvx - qmul(c, pvx) + qmul(s, pvy) + offx);
                    l12 = sat32(pvy - qmul(s, pvx) - qmul(c, pvy) + offy);
                    for (int j = 0; j < 6; j++) p[j] = mat[j];
                    mat[0] = sat32(qmul(p[0], c) + qmul(p[1], s));
                    mat[1] = sat32(qmul(p[0], -s) + qmul(p[1], c));
                    mat[2] = sat32(qmul(p[0], l02) + qmul(p[1], l12) + p[2]);
                    mat[3] = sat32(qmul(p[3], c) + qmul(p[4], s));
                    mat[4] = sat32(qmul(p[3], -s) + qmul(p[4], c));
                    mat[5] = sat32(qmul(p[3], l02) + qmul(p[4], l12) + p[5]);
                    if (al < cur_a) cur_a = al;
                end
            end
            atst_pkg::CMD_PUSH_ID: begin
                if (level >= 8) fault = 1;
                else begin
                    push_state();
                    mat = '{65536, 0, 0, 0, 65536, 0};
                    cur_a = 256;
                end
            end
            atst_pkg::CMD_POP: begin
                if (level == 0) fault = 1;
                else begin
                    level--;
                    for (int j = 0; j < 6; j++) mat[j] = sv_mat[level][j];
                    cur_a = sv_a[level];
                    clip_en = sv_clip[level];
                    for (int j = 0; j < 4; j++) rect[j] = sv_rect[level][j];
                end
            end
            atst_pkg::CMD_POINT: begin
                scaled = (longint'(col[31:24]) * cur_a) >> 8;
                na = (scaled > 255) ? 8'hFF : scaled[7:0];
                map_point(cx, cy, rx, ry);
                rcol = {na, col[23:0]};
            end
            atst_pkg::CMD_SCISSOR: begin
                map_point(cx, cy, xs[0], ys[0]);
                map_point(cx2, cy, xs[1], ys[1]);
                map_point(cx2, cy2, xs[2], ys[2]);
                map_point(cx, cy2, xs[3], ys[3]);
                mnx = xs[0]; mxx = xs[0]; mny = ys[0]; mxy = ys[0];
                for (int j = 1; j < 4; j++) begin
                    if (xs[j] < mnx) mnx = xs[j];
                    if (xs[j] > mxx) mxx = xs[j];
                    if (ys[j] < mny) mny = ys[j];
                    if (ys[j] > mxy) mxy = ys[j];
                end
                rect[0] = sat16(mnx >>> 16);
                rect[1] = sat16(mny >>> 16);
                rect[2] = sat16(-((-mxx) >>> 16));
                rect[3] = sat16(-((-mxy) >>> 16));
                clip_en = 1;
            end
            atst_pkg::CMD_CLIP_OFF: clip_en = 0;
            default: ;
        endcase
        want_data.insert(want_data.size(), {7'd0, rect[3], rect[2], rect[1], rect[0],
                                            clip_en, rcol, ry[31:0], rx[31:0]});
        want_fault.insert(want_fault.size(), fault);
    endfunction

    function void check_result(logic [167:0] got, logic got_fault);
        logic [167:0] exp_d;
        logic exp_f;
        if (want_data.size() == 0) begin
            $display("%0t: result beat with nothing expected: %h", $time, got);
            errors++;
            return;
        end
        exp_d = want_data.pop_front();
        exp_f = want_fault.pop_front();
        if (got[31:0] !== exp_d[31:0])
            $display("%0t: out_x exp %h got %h", $time, exp_d[31:0], got[31:0]);
        if (got[63:32] !== exp_d[63:32])
            $display("%0t: out_y exp %h got %h", $time, exp_d[63:32], got[63:32]);
        if (got[95:64] !== exp_d[95:64])
            $display("%0t: out_color exp %h got %h", $time, exp_d[95:64], got[95:64]);
        if (got[96] !== exp_d[96])
            $display("%0t: clip_on exp %b got %b", $time, exp_d[96], got[96]);
        if (got[160:97] !== exp_d[160:97])
            $display("%0t: clip rect exp %h got %h", $time, exp_d[160:97], got[160:97]);
        if (got_fault !== exp_f)
            $display("%0t: stack_fault exp %b got %b", $time, exp_f, got_fault);
        if (got[160:0] !== exp_d[160:0] || got_fault !== exp_f) errors++;
    endfunction
endclass

module tb_affine_transform_stack_2d_top;
    import atst_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;
    logic         m_axis_tuser;

    transform_scoreboard board;
    logic calm;
    logic feeding;
    int   idle_cycles;

    affine_transform_stack_2d_top dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Random busy words; some corner values, mostly random.
    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            5, 6: return 32'($signed($urandom_range(0, 400)) - 200) << 16;
            default: return $urandom;
        endcase
    endfunction

    // Valid stays high between back-to-back beats and drops only while idling.
    task automatic send_beat(logic [2:0] op, logic [8:0] al, logic [15:0] ang,
                             logic [31:0] offx, logic [31:0] offy,
                             logic [31:0] pvx, logic [31:0] pvy,
                             logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cx2, logic [31:0] cy2, logic [31:0] col);
        while (!calm && $urandom_range(0, 99) < 27) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, col, cy2, cx2, cy, cx, pvy, pvx, offy, offx, ang, al};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_input(op, al, ang, offx, offy, pvx, pvy, cx, cy, cx2, cy2, col);
    endtask

    task automatic send_random(logic [2:0] op);
        send_beat(op, 9'($urandom_range(0, 511)), 16'($urandom), rnd_word(), rnd_word(),
                  rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                  $urandom);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= calm || $urandom_range(0, 99) >= 27;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int r;
        board = new();
        calm = 0;
        idle_cycles = 0;
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty pop, field extremes, every command, stack overflow.
        send_beat(CMD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(CMD_POINT, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                  32'hFFFF_FFFF);
        send_beat(CMD_SCISSOR, 0, 0, 0, 0, 0, 0, 32'h0010_8000, 32'hFFF0_0000,
                  32'hFFFF_0001, 32'h0020_0000, 0);
        send_beat(CMD_PUSH_ROT, 9'h1FF, 16'h4000, 32'h0001_0000, 32'hFFFF_0000,
                  32'h000A_0000, 32'h0005_0000, 0, 0, 0, 0, 0);
        send_beat(CMD_POINT, 0, 0, 0, 0, 0, 0, 32'h0003_0000, 32'h0007_8000, 0, 0,
                  32'h80AB_CDEF);
        send_beat(CMD_PUSH_ROT, 9'd128, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_beat(CMD_SCISSOR, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_beat(CMD_CLIP_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(CMD_POINT, 0, 0, 0, 0, 0, 0, 32'h1234_5678, 32'hEDCB_A987, 0, 0,
                  32'hFF00_0000);
        for (int i = 0; i < 7; i++) send_beat(CMD_PUSH_ID, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(CMD_PUSH_ROT, 9'h100, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 9; i++) send_beat(CMD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(3'd6, 9'h1FF, 16'hFFFF, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        send_beat(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        s_axis_tvalid <= 0;

        // Hold off until everything queued so far has come back.
        while (board.want_data.size() != 0) @(posedge aclk);

        for (int n = 0; n < 1550; n++) begin
            calm = (n >= 600 && n < 800);
            r = $urandom_range(0, 99);
            if (r < 18) send_random(CMD_PUSH_ROT);
            else if (r < 28) send_random(CMD_PUSH_ID);
            else if (r < 48) send_random(CMD_POP);
            else if (r < 78) send_random(CMD_POINT);
            else if (r < 90) send_random(CMD_SCISSOR);
            else if (r < 97) send_random(CMD_CLIP_OFF);
            else send_random(3'($urandom_range(6, 7)));
        end
        calm = 0;
        s_axis_tvalid <= 0;

        while (board.want_data.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.errors == 0 && board.want_data.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
